/* rtl/dtfp_pkg.sv */
// shared types and constants for the decimal text to fixed-point parser
// standalone package, no dependencies
package dtfp_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_MODE = 2'd1;

  localparam logic [4:0] FRAC_BITS_RESET = 5'd10;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  localparam logic [31:0] INT32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] parsed_value;
    logic [7:0]         consumed_count;
    logic               overflow_seen;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PREP,
    ST_DIV,
    ST_ADD,
    ST_DONE
  } state_t;

endpackage

/* rtl/decimal_text_to_fixed_point.sv */
// top level of the decimal text to fixed-point parser
// depends on dtfp_pkg
//
// One character word is taken per cycle while the parser is idle; a non-last
// character is absorbed in the cycle it is accepted. A last character starts
// the result sequence: accept, shift and output load when no fraction term
// is needed; accept, shift, numerator load, 64 divide steps, add and output
// load when one is. The divide steps are run by the bit-serial restoring
// divider, 64 steps through a single 33-bit subtractor. One shifter
// serves both the integer scaling and the divider's numerator. The finished
// result sits in an output register, so characters of the next value are
// accepted while it waits to be taken. No clearing pass after reset.
module decimal_text_to_fixed_point #(
  parameter int MAX_TEXT_LEN = 255
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dtfp_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dtfp_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dtfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int LIMIT_INT = (MAX_TEXT_LEN < 255) ? MAX_TEXT_LEN : 255;
  localparam logic [7:0] LIMIT = 8'(LIMIT_INT);

  dtfp_pkg::state_t state_r, state_nxt;

  logic [4:0]  frac_bits_r, frac_bits_nxt;
  logic        int_mode_r, int_mode_nxt;

  logic [31:0] acc_r, acc_nxt;
  logic [31:0] ipart_r, ipart_nxt;
  logic [31:0] fscale_r, fscale_nxt;
  logic        dot_r, dot_nxt;
  logic        neg_r, neg_nxt;
  logic        stop_r, stop_nxt;
  logic        wrap_r, wrap_nxt;
  logic [7:0]  pos_r, pos_nxt;

  logic [31:0] res_r, res_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] div_r, div_nxt;
  logic        qneg_r, qneg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  dtfp_pkg::out_word_t out_word_r, out_word_nxt;

  logic        in_acc;
  logic        out_free;
  logic [35:0] acc_x10;
  logic [35:0] fsc_x10;
  logic        acc_ovf;
  logic        fsc_ovf;
  logic [31:0] ipart_sel;
  logic [31:0] acc_mag;
  logic [63:0] shf_in;
  logic [63:0] shf_out;
  logic        shf_ovf;
  logic        frac_term;
  logic [31:0] rem_sh;
  logic [32:0] rem_diff;
  logic [63:0] quo_s;
  logic        quo_ovf;
  logic [32:0] sum33;
  logic [31:0] res_final;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != dtfp_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // per-character accumulate
  assign acc_x10 = ({{4{acc_r[31]}}, acc_r} << 3) + ({{4{acc_r[31]}}, acc_r} << 1)
                 + {32'd0, in_word.text_byte[3:0]};
  assign fsc_x10 = ({{4{fscale_r[31]}}, fscale_r} << 3)
                 + ({{4{fscale_r[31]}}, fscale_r} << 1);
  assign acc_ovf = !((acc_x10[35:31] == 5'b00000) || (acc_x10[35:31] == 5'b11111));
  assign fsc_ovf = !((fsc_x10[35:31] == 5'b00000) || (fsc_x10[35:31] == 5'b11111));

  // shared shifter
  assign ipart_sel = dot_r ? ipart_r : acc_r;
  assign acc_mag   = acc_r[31] ? (32'd0 - acc_r) : acc_r;
  assign shf_in    = (state_r == dtfp_pkg::ST_PREP) ? {32'd0, acc_mag}
                                                    : {{32{ipart_sel[31]}}, ipart_sel};
  assign shf_out   = shf_in << frac_bits_r;
  assign shf_ovf   = !((shf_out[63:31] == {33{1'b0}}) || (shf_out[63:31] == {33{1'b1}}));
  assign frac_term = dot_r && !fscale_r[31] && (fscale_r[30:1] != 30'd0);

  // divider step
  assign rem_sh   = {rem_r[30:0], dvd_r[63]};
  assign rem_diff = {1'b0, rem_sh} - {1'b0, div_r};

  assign quo_s   = qneg_r ? (64'd0 - dvd_r) : dvd_r;
  assign quo_ovf = !((quo_s[63:31] == {33{1'b0}}) || (quo_s[63:31] == {33{1'b1}}));
  assign sum33   = {res_r[31], res_r} + {quo_s[31], quo_s[31:0]};

  assign res_final = neg_r ? (32'd0 - res_r) : res_r;

  always_comb begin
    state_nxt     = state_r;
    frac_bits_nxt = frac_bits_r;
    int_mode_nxt  = int_mode_r;
    acc_nxt       = acc_r;
    ipart_nxt     = ipart_r;
    fscale_nxt    = fscale_r;
    dot_nxt       = dot_r;
    neg_nxt       = neg_r;
    stop_nxt      = stop_r;
    wrap_nxt      = wrap_r;
    pos_nxt       = pos_r;
    res_nxt       = res_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    qneg_nxt      = qneg_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtfp_pkg::CFG_FRAC_BITS:    frac_bits_nxt = cfg_data;
        dtfp_pkg::CFG_INTEGER_MODE: int_mode_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      dtfp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!stop_r) begin
            if (pos_r >= LIMIT) begin
              stop_nxt = 1'b1;
            end else if (in_word.text_byte inside
                         {[dtfp_pkg::CHAR_ZERO:dtfp_pkg::CHAR_NINE]}) begin
              acc_nxt  = acc_x10[31:0];
              wrap_nxt = wrap_r | acc_ovf | (dot_r & fsc_ovf);
              if (dot_r) begin
                fscale_nxt = fsc_x10[31:0];
              end
              pos_nxt = pos_r + 8'd1;
            end else if (in_word.text_byte == dtfp_pkg::CHAR_DOT && !int_mode_r && !dot_r) begin
              ipart_nxt  = acc_r;
              acc_nxt    = 32'd0;
              fscale_nxt = 32'd1;
              dot_nxt    = 1'b1;
              pos_nxt    = pos_r + 8'd1;
            end else if (in_word.text_byte == dtfp_pkg::CHAR_MINUS && pos_r == 8'd0) begin
              neg_nxt = 1'b1;
              pos_nxt = pos_r + 8'd1;
            end else begin
              stop_nxt = 1'b1;
            end
          end
          if (in_word.last_byte) begin
            state_nxt = dtfp_pkg::ST_SHIFT;
          end
        end
      end
      dtfp_pkg::ST_SHIFT: begin
        if (int_mode_r) begin
          res_nxt   = ipart_sel;
          state_nxt = dtfp_pkg::ST_DONE;
        end else begin
          res_nxt   = shf_out[31:0];
          wrap_nxt  = wrap_r | shf_ovf;
          state_nxt = frac_term ? dtfp_pkg::ST_PREP : dtfp_pkg::ST_DONE;
        end
      end
      dtfp_pkg::ST_PREP: begin
        dvd_nxt   = shf_out;
        rem_nxt   = 32'd0;
        div_nxt   = fscale_r;
        qneg_nxt  = acc_r[31];
        cnt_nxt   = 6'd0;
        state_nxt = dtfp_pkg::ST_DIV;
      end
      dtfp_pkg::ST_DIV: begin
        if (!rem_diff[32]) begin
          rem_nxt = rem_diff[31:0];
          dvd_nxt = {dvd_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          dvd_nxt = {dvd_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = dtfp_pkg::ST_ADD;
        end
      end
      dtfp_pkg::ST_ADD: begin
        res_nxt   = sum33[31:0];
        wrap_nxt  = wrap_r | quo_ovf | (sum33[32] != sum33[31]);
        state_nxt = dtfp_pkg::ST_DONE;
      end
      dtfp_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_word_nxt.parsed_value    = res_final;
          out_word_nxt.consumed_count  = pos_r;
          out_word_nxt.overflow_seen   = wrap_r | (neg_r && res_r == dtfp_pkg::INT32_MIN);
          acc_nxt    = 32'd0;
          ipart_nxt  = 32'd0;
          fscale_nxt = 32'd0;
          dot_nxt    = 1'b0;
          neg_nxt    = 1'b0;
          stop_nxt   = 1'b0;
          wrap_nxt   = 1'b0;
          pos_nxt    = 8'd0;
          state_nxt  = dtfp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dtfp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtfp_pkg::ST_IDLE;
      frac_bits_r <= dtfp_pkg::FRAC_BITS_RESET;
      int_mode_r  <= 1'b0;
      acc_r       <= 32'd0;
      ipart_r     <= 32'd0;
      fscale_r    <= 32'd0;
      dot_r       <= 1'b0;
      neg_r       <= 1'b0;
      stop_r      <= 1'b0;
      wrap_r      <= 1'b0;
      pos_r       <= 8'd0;
      cnt_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frac_bits_r <= frac_bits_nxt;
      int_mode_r  <= int_mode_nxt;
      acc_r       <= acc_nxt;
      ipart_r     <= ipart_nxt;
      fscale_r    <= fscale_nxt;
      dot_r       <= dot_nxt;
      neg_r       <= neg_nxt;
      stop_r      <= stop_nxt;
      wrap_r      <= wrap_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    qneg_r     <= qneg_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

/* rtl/dtfp_checker.sv */
// port-level checker for the decimal text to fixed-point parser
// depends on dtfp_pkg, bound to decimal_text_to_fixed_point
module dtfp_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input dtfp_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input dtfp_pkg::out_word_t out_word
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // a held output word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // a last character closes the input until its result is formed
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.last_byte |=> in_stall)
    else $error("input accepted right after a last character");

  // a non-last character never produces a word on its own
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_word.last_byte && !out_valid |=> !out_valid)
    else $error("output word without a last character");

endmodule

bind decimal_text_to_fixed_point dtfp_port_checker u_dtfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
